// ===== hw/rtl/idea_pkg.sv =====
`default_nettype none

package idea_pkg;

    localparam int STORE_DEPTH = 256;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int IDX_W       = 10;
    localparam int REQ_W       = 3;
    localparam int STAT_W      = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_READ       = 3'd4,
        REQ_WRITE      = 3'd5,
        REQ_REMOVE     = 3'd6
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } stat_t;

    typedef enum logic {
        SEL_FRONT = 1'b0,
        SEL_BACK  = 1'b1
    } sel_t;

    typedef struct packed {
        logic              accept;
        logic              wr_en;
        logic              rd_en;
        sel_t              sel;
        logic [ADDR_W-1:0] addr;
        logic              shift_rd;
        logic              capture;
        logic              capture_zero;
        logic              load_out;
    } dp_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/idea_dp.sv =====
`default_nettype none

module idea_dp (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire idea_pkg::dp_cmd_t            cmd,
    input  wire logic [idea_pkg::DATA_W-1:0]  in_data,
    output logic      [idea_pkg::DATA_W-1:0]  out_data
);

    logic [idea_pkg::DATA_W-1:0] front_mem [idea_pkg::STORE_DEPTH];
    logic [idea_pkg::DATA_W-1:0] back_mem  [idea_pkg::STORE_DEPTH];

    logic [idea_pkg::DATA_W-1:0] din_reg;
    logic [idea_pkg::DATA_W-1:0] front_rd_reg;
    logic [idea_pkg::DATA_W-1:0] back_rd_reg;
    idea_pkg::sel_t              rd_sel_reg;
    logic [idea_pkg::DATA_W-1:0] rd_data;

    logic                        sh_pend_reg;
    logic [idea_pkg::ADDR_W-1:0] sh_addr_reg;
    idea_pkg::sel_t              sh_sel_reg;

    logic [idea_pkg::DATA_W-1:0] res_data_reg;
    logic [idea_pkg::DATA_W-1:0] out_data_reg;

    logic                        front_we;
    logic                        back_we;
    logic [idea_pkg::ADDR_W-1:0] wr_addr;
    logic [idea_pkg::DATA_W-1:0] wr_data;
    logic                        front_re;
    logic                        back_re;

    assign rd_data = (rd_sel_reg == idea_pkg::SEL_FRONT) ? front_rd_reg : back_rd_reg;

    // a shift write lands in the cycle after its read and never meets a direct write
    always_comb begin
        if (sh_pend_reg) begin
            front_we = (sh_sel_reg == idea_pkg::SEL_FRONT);
            back_we  = (sh_sel_reg == idea_pkg::SEL_BACK);
            wr_addr  = sh_addr_reg;
            wr_data  = rd_data;
        end else begin
            front_we = cmd.wr_en && (cmd.sel == idea_pkg::SEL_FRONT);
            back_we  = cmd.wr_en && (cmd.sel == idea_pkg::SEL_BACK);
            wr_addr  = cmd.addr;
            wr_data  = din_reg;
        end
    end

    assign front_re = cmd.rd_en && (cmd.sel == idea_pkg::SEL_FRONT);
    assign back_re  = cmd.rd_en && (cmd.sel == idea_pkg::SEL_BACK);

    always_ff @(posedge aclk) begin
        if (front_we) begin
            front_mem[wr_addr] <= wr_data;
        end
        if (front_re) begin
            front_rd_reg <= front_mem[cmd.addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (back_we) begin
            back_mem[wr_addr] <= wr_data;
        end
        if (back_re) begin
            back_rd_reg <= back_mem[cmd.addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sh_pend_reg <= 1'b0;
        end else begin
            sh_pend_reg <= cmd.shift_rd;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            din_reg <= in_data;
        end
        if (cmd.rd_en) begin
            rd_sel_reg <= cmd.sel;
        end
        sh_addr_reg <= cmd.addr - idea_pkg::ADDR_W'(1);
        sh_sel_reg  <= cmd.sel;
        if (cmd.capture) begin
            res_data_reg <= cmd.capture_zero ? '0 : rd_data;
        end
        if (cmd.load_out) begin
            out_data_reg <= res_data_reg;
        end
    end

    assign out_data = out_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/idea_ctrl.sv =====
`default_nettype none

module idea_ctrl (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [idea_pkg::REQ_W-1:0]    in_req,
    input  wire logic [idea_pkg::IDX_W-1:0]    in_index,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output idea_pkg::stat_t                    out_status,
    output logic      [idea_pkg::IDX_W-1:0]    out_count,
    output idea_pkg::dp_cmd_t                  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT,
        S_WRAP,
        S_FINISH
    } state_t;

    localparam logic [idea_pkg::CNT_W-1:0] DEPTH_CNT = idea_pkg::CNT_W'(idea_pkg::STORE_DEPTH);

    state_t                       state_reg,   state_next;
    idea_pkg::req_t               req_reg,     req_next;
    logic [idea_pkg::IDX_W-1:0]   idx_reg,     idx_next;
    logic [idea_pkg::CNT_W-1:0]   fc_reg,      fc_next;
    logic [idea_pkg::CNT_W-1:0]   bc_reg,      bc_next;
    idea_pkg::stat_t              pend_reg,    pend_next;
    logic [idea_pkg::CNT_W-1:0]   ptr_reg,     ptr_next;
    logic [idea_pkg::CNT_W-1:0]   end_reg,     end_next;
    idea_pkg::sel_t               shsel_reg,   shsel_next;
    logic                         cap_reg,     cap_next;
    logic                         capz_reg,    capz_next;
    logic                         mvalid_reg,  mvalid_next;
    idea_pkg::stat_t              mstat_reg,   mstat_next;
    logic [idea_pkg::IDX_W-1:0]   mcount_reg,  mcount_next;

    logic [idea_pkg::IDX_W-1:0]   fc_ext;
    logic [idea_pkg::IDX_W-1:0]   total;
    logic                         in_front;
    logic [idea_pkg::IDX_W-1:0]   front_diff;
    logic [idea_pkg::IDX_W-1:0]   back_diff;
    logic [idea_pkg::CNT_W-1:0]   fc_last;
    logic [idea_pkg::CNT_W-1:0]   bc_last;

    idea_pkg::stat_t              d_status;
    logic                         d_wr;
    logic                         d_rd;
    idea_pkg::sel_t               d_sel;
    logic [idea_pkg::ADDR_W-1:0]  d_addr;
    logic                         d_shift_req;
    idea_pkg::sel_t               d_ssel;
    logic [idea_pkg::ADDR_W-1:0]  d_s;
    logic [idea_pkg::CNT_W-1:0]   d_n;
    logic [idea_pkg::CNT_W-1:0]   d_start;
    logic                         d_shift;
    logic [idea_pkg::CNT_W-1:0]   d_fc;
    logic [idea_pkg::CNT_W-1:0]   d_bc;
    logic                         out_free;

    assign fc_ext     = idea_pkg::IDX_W'(fc_reg);
    assign total      = fc_ext + idea_pkg::IDX_W'(bc_reg);
    assign in_front   = idx_reg < fc_ext;
    assign front_diff = fc_ext - idea_pkg::IDX_W'(1) - idx_reg;
    assign back_diff  = idx_reg - fc_ext;
    assign fc_last    = fc_reg - idea_pkg::CNT_W'(1);
    assign bc_last    = bc_reg - idea_pkg::CNT_W'(1);

    // request decode against the current counts
    always_comb begin
        d_status    = idea_pkg::ST_RANGE;
        d_wr        = 1'b0;
        d_rd        = 1'b0;
        d_sel       = idea_pkg::SEL_FRONT;
        d_addr      = '0;
        d_shift_req = 1'b0;
        d_ssel      = idea_pkg::SEL_FRONT;
        d_s         = '0;
        d_n         = '0;
        d_fc        = fc_reg;
        d_bc        = bc_reg;
        unique case (req_reg)
            idea_pkg::REQ_PUSH_FRONT: begin
                if (fc_reg == DEPTH_CNT) begin
                    d_status = idea_pkg::ST_FULL;
                end else begin
                    d_status = idea_pkg::ST_OK;
                    d_wr     = 1'b1;
                    d_sel    = idea_pkg::SEL_FRONT;
                    d_addr   = fc_reg[idea_pkg::ADDR_W-1:0];
                    d_fc     = fc_reg + idea_pkg::CNT_W'(1);
                end
            end
            idea_pkg::REQ_PUSH_BACK: begin
                if (bc_reg == DEPTH_CNT) begin
                    d_status = idea_pkg::ST_FULL;
                end else begin
                    d_status = idea_pkg::ST_OK;
                    d_wr     = 1'b1;
                    d_sel    = idea_pkg::SEL_BACK;
                    d_addr   = bc_reg[idea_pkg::ADDR_W-1:0];
                    d_bc     = bc_reg + idea_pkg::CNT_W'(1);
                end
            end
            idea_pkg::REQ_POP_FRONT: begin
                if (total != '0) begin
                    d_status = idea_pkg::ST_OK;
                    d_rd     = 1'b1;
                    if (fc_reg != '0) begin
                        d_sel  = idea_pkg::SEL_FRONT;
                        d_addr = fc_last[idea_pkg::ADDR_W-1:0];
                        d_fc   = fc_last;
                    end else begin
                        d_sel       = idea_pkg::SEL_BACK;
                        d_shift_req = 1'b1;
                        d_ssel      = idea_pkg::SEL_BACK;
                        d_n         = bc_reg;
                        d_bc        = bc_last;
                    end
                end
            end
            idea_pkg::REQ_POP_BACK: begin
                if (total != '0) begin
                    d_status = idea_pkg::ST_OK;
                    d_rd     = 1'b1;
                    if (bc_reg != '0) begin
                        d_sel  = idea_pkg::SEL_BACK;
                        d_addr = bc_last[idea_pkg::ADDR_W-1:0];
                        d_bc   = bc_last;
                    end else begin
                        d_sel       = idea_pkg::SEL_FRONT;
                        d_shift_req = 1'b1;
                        d_ssel      = idea_pkg::SEL_FRONT;
                        d_n         = fc_reg;
                        d_fc        = fc_last;
                    end
                end
            end
            idea_pkg::REQ_READ: begin
                if (idx_reg < total) begin
                    d_status = idea_pkg::ST_OK;
                    d_rd     = 1'b1;
                    d_sel    = in_front ? idea_pkg::SEL_FRONT : idea_pkg::SEL_BACK;
                    d_addr   = in_front ? front_diff[idea_pkg::ADDR_W-1:0]
                                        : back_diff[idea_pkg::ADDR_W-1:0];
                end
            end
            idea_pkg::REQ_WRITE: begin
                if (idx_reg == total) begin
                    if (bc_reg == DEPTH_CNT) begin
                        d_status = idea_pkg::ST_FULL;
                    end else begin
                        d_status = idea_pkg::ST_OK;
                        d_wr     = 1'b1;
                        d_sel    = idea_pkg::SEL_BACK;
                        d_addr   = bc_reg[idea_pkg::ADDR_W-1:0];
                        d_bc     = bc_reg + idea_pkg::CNT_W'(1);
                    end
                end else if (idx_reg < total) begin
                    d_status = idea_pkg::ST_OK;
                    d_wr     = 1'b1;
                    d_sel    = in_front ? idea_pkg::SEL_FRONT : idea_pkg::SEL_BACK;
                    d_addr   = in_front ? front_diff[idea_pkg::ADDR_W-1:0]
                                        : back_diff[idea_pkg::ADDR_W-1:0];
                end
            end
            idea_pkg::REQ_REMOVE: begin
                if (idx_reg < total) begin
                    d_status    = idea_pkg::ST_OK;
                    d_shift_req = 1'b1;
                    if (in_front) begin
                        d_ssel = idea_pkg::SEL_FRONT;
                        d_s    = front_diff[idea_pkg::ADDR_W-1:0];
                        d_n    = fc_reg;
                        d_fc   = fc_last;
                    end else begin
                        d_ssel = idea_pkg::SEL_BACK;
                        d_s    = back_diff[idea_pkg::ADDR_W-1:0];
                        d_n    = bc_reg;
                        d_bc   = bc_last;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign d_start  = idea_pkg::CNT_W'(d_s) + idea_pkg::CNT_W'(1);
    assign d_shift  = d_shift_req && (d_start < d_n);
    assign out_free = !mvalid_reg || m_tready;

    always_comb begin
        state_next  = state_reg;
        req_next    = req_reg;
        idx_next    = idx_reg;
        fc_next     = fc_reg;
        bc_next     = bc_reg;
        pend_next   = pend_reg;
        ptr_next    = ptr_reg;
        end_next    = end_reg;
        shsel_next  = shsel_reg;
        cap_next    = 1'b0;
        capz_next   = capz_reg;
        mvalid_next = mvalid_reg && !m_tready;
        mstat_next  = mstat_reg;
        mcount_next = mcount_reg;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    req_next   = idea_pkg::req_t'(in_req);
                    idx_next   = in_index;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.wr_en  = d_wr;
                cmd.rd_en  = d_rd;
                cmd.sel    = d_sel;
                cmd.addr   = d_addr;
                pend_next  = d_status;
                fc_next    = d_fc;
                bc_next    = d_bc;
                cap_next   = 1'b1;
                capz_next  = !d_rd;
                ptr_next   = d_start;
                end_next   = d_n;
                shsel_next = d_ssel;
                state_next = d_shift ? S_SHIFT : S_WRAP;
            end
            S_SHIFT: begin
                cmd.rd_en    = 1'b1;
                cmd.shift_rd = 1'b1;
                cmd.sel      = shsel_reg;
                cmd.addr     = ptr_reg[idea_pkg::ADDR_W-1:0];
                ptr_next     = ptr_reg + idea_pkg::CNT_W'(1);
                if (ptr_next == end_reg) begin
                    state_next = S_WRAP;
                end
            end
            S_WRAP: begin
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    mvalid_next  = 1'b1;
                    mstat_next   = pend_reg;
                    mcount_next  = total;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        cmd.capture      = cap_reg;
        cmd.capture_zero = capz_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            fc_reg     <= '0;
            bc_reg     <= '0;
            cap_reg    <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            fc_reg     <= fc_next;
            bc_reg     <= bc_next;
            cap_reg    <= cap_next;
            mvalid_reg <= mvalid_next;
        end
        req_reg    <= req_next;
        idx_reg    <= idx_next;
        pend_reg   <= pend_next;
        ptr_reg    <= ptr_next;
        end_reg    <= end_next;
        shsel_reg  <= shsel_next;
        capz_reg   <= capz_next;
        mstat_reg  <= mstat_next;
        mcount_reg <= mcount_next;
    end

    assign s_tready   = (state_reg == S_IDLE);
    assign m_tvalid   = mvalid_reg;
    assign out_status = mstat_reg;
    assign out_count  = mcount_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/indexed_double_ended_array.sv =====
// a request goes through decode, an optional shift state, wrap and finish to its result beat
// a shift (remove, or pop that crosses to the other store) moves the entries above the
// removed slot one at a time through the store's read port and write port
// one request is in work at a time; a new beat is taken while a result waits
// reset: synchronous, active low; both counts clear to zero, store contents are kept
`default_nettype none

module indexed_double_ended_array (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // index[9:0], data_in[41:10], zero fill
    input  wire logic [2:0]  s_tuser,   // req_type[2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata,   // data_out[31:0], element_count[41:32], zero fill
    output logic      [1:0]  m_tuser    // status[1:0]
);

    idea_pkg::dp_cmd_t                    cmd;
    idea_pkg::stat_t                      out_status;
    logic [idea_pkg::IDX_W-1:0]           out_count;
    logic [idea_pkg::DATA_W-1:0]          out_data;

    idea_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .in_req     (s_tuser),
        .in_index   (s_tdata[idea_pkg::IDX_W-1:0]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .out_status (out_status),
        .out_count  (out_count),
        .cmd        (cmd)
    );

    idea_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_data  (s_tdata[idea_pkg::IDX_W +: idea_pkg::DATA_W]),
        .out_data (out_data)
    );

    assign m_tdata = {6'd0, out_count, out_data};
    assign m_tuser = out_status;

endmodule

`default_nettype wire

// ===== hw/rtl/idea_chk.sv =====
`default_nettype none

module idea_chk (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat shown right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while one is in work");

    a_fail_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != 2'd0) |-> m_tdata[31:0] == 32'd0)
        else $error("failed request returned data");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[41:32] <= 10'd512)
        else $error("element count beyond both stores");

endmodule

bind indexed_double_ended_array idea_chk u_chk (.*);

`default_nettype wire
